[src/mi4_pkg.sv]
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared constants and request/response types for the 4x4 matrix inverter.
// ----------------------------------------------------------------------------
package mi4_pkg;

  localparam int MAX_ORDER = 4;
  localparam int FRAC_BITS = 16;
  localparam int CELLS     = MAX_ORDER * MAX_ORDER;
  localparam int WORD_W    = 32;
  localparam int WIDE_W    = 64;
  localparam int DIV_STEPS = WIDE_W + FRAC_BITS;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SING = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  typedef struct packed {
    logic                     start;
    logic signed [WIDE_W-1:0] a;
    logic signed [WIDE_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [WIDE_W-1:0] res;
    logic                     sat;
  } mul_rsp_t;

  typedef struct packed {
    logic                     start;
    logic signed [WIDE_W-1:0] num;
    logic signed [WIDE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [WORD_W-1:0] quo;
    logic                     sat;
  } div_rsp_t;

endpackage

[src/mi4_elem_if.sv]
// ----------------------------------------------------------------------------
// mi4_elem_if
// Input element channel: one signed Q16.16 matrix element per transfer.
// ----------------------------------------------------------------------------
interface mi4_elem_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

[src/mi4_cfg_if.sv]
// ----------------------------------------------------------------------------
// mi4_cfg_if
// Configuration write channel for the matrix_size register.
// ----------------------------------------------------------------------------
interface mi4_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] matrix_size;

  modport source (output valid, output matrix_size, input ready);
  modport sink   (input valid, input matrix_size, output ready);
endinterface

[src/mi4_res_if.sv]
// ----------------------------------------------------------------------------
// mi4_res_if
// Result channel: one inverse element with status and last mark per transfer.
// ----------------------------------------------------------------------------
interface mi4_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] inverse_element;
  logic [1:0]         status_code;
  logic               last_result;

  modport source (output valid, output inverse_element, output status_code,
                  output last_result, input ready);
  modport sink   (input valid, input inverse_element, input status_code,
                  input last_result, output ready);
endinterface

[src/mi4_mul.sv]
// ----------------------------------------------------------------------------
// mi4_mul
// Shared Q-format multiplier: 64x64 magnitude product built from four 32x32
// partial products, rounded half away from zero, saturated to +-(2^63-1).
// ----------------------------------------------------------------------------
module mi4_mul (
  input  logic              clk,
  input  logic              rst,
  input  mi4_pkg::mul_req_t req,
  output mi4_pkg::mul_rsp_t rsp
);

  localparam logic [2:0] LAST_STEP = 3'd6;
  localparam logic [127:0] ROUND_BIAS = 128'(1) << (mi4_pkg::FRAC_BITS - 1);
  localparam logic [63:0] MAG_MAX = {1'b0, {63{1'b1}}};

  logic        busy;
  logic [2:0]  step;
  logic        done;
  logic [63:0] xm;
  logic [63:0] ym;
  logic        neg;
  logic [63:0] pp;
  logic [1:0]  psh;
  logic [127:0] acc;
  logic signed [63:0] res;
  logic        sat;

  logic [31:0]  xsel;
  logic [31:0]  ysel;
  logic [127:0] pp_shift;
  logic         q_sat;
  logic [63:0]  q_mag;

  assign xsel = step[1] ? xm[63:32] : xm[31:0];
  assign ysel = step[0] ? ym[63:32] : ym[31:0];

  always_comb begin
    unique case (psh)
      2'd0:    pp_shift = {64'd0, pp};
      2'd1:    pp_shift = {32'd0, pp, 32'd0};
      default: pp_shift = {pp, 64'd0};
    endcase
  end

  assign q_sat = |acc[127:mi4_pkg::FRAC_BITS+63];
  assign q_mag = q_sat ? MAG_MAX : {1'b0, acc[mi4_pkg::FRAC_BITS+62:mi4_pkg::FRAC_BITS]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      xm  <= req.a[63] ? 64'(-req.a) : req.a;
      ym  <= req.b[63] ? 64'(-req.b) : req.b;
      neg <= req.a[63] ^ req.b[63];
      acc <= '0;
    end else if (busy) begin
      if (step < 3'd4) begin
        pp  <= xsel * ysel;
        psh <= {1'b0, step[1]} + {1'b0, step[0]};
      end
      if (step >= 3'd1 && step <= 3'd4) acc <= acc + pp_shift;
      if (step == 3'd5) acc <= acc + ROUND_BIAS;
      if (step == LAST_STEP) begin
        res <= neg ? -$signed(q_mag) : $signed(q_mag);
        sat <= q_sat;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;
  assign rsp.sat  = sat;

endmodule

[src/mi4_div.sv]
// ----------------------------------------------------------------------------
// mi4_div
// Radix-2 restoring divider: (num << FRAC_BITS) / den, one quotient bit per
// cycle, rounded half away from zero and saturated to the signed 32-bit range.
// ----------------------------------------------------------------------------
module mi4_div (
  input  logic              clk,
  input  logic              rst,
  input  mi4_pkg::div_req_t req,
  output mi4_pkg::div_rsp_t rsp
);

  localparam int DQ_W = mi4_pkg::DIV_STEPS;
  localparam logic [6:0] ROUND_STEP = 7'(mi4_pkg::DIV_STEPS);
  localparam logic [6:0] LAST_STEP  = 7'(mi4_pkg::DIV_STEPS + 1);

  logic            busy;
  logic [6:0]      cnt;
  logic            done;
  logic [63:0]     md;
  logic [63:0]     rem;
  logic [DQ_W-1:0] dq;
  logic [DQ_W:0]   qr;
  logic            neg;
  logic signed [31:0] quo;
  logic            sat;

  logic [64:0]     rem2;
  logic            ge;
  logic            up;
  logic [DQ_W:0]   lim;
  logic            q_sat;
  logic [31:0]     q_mag;

  assign rem2  = {rem, dq[DQ_W-1]};
  assign ge    = rem2 >= {1'b0, md};
  assign up    = {rem, 1'b0} >= {1'b0, md};
  assign lim   = neg ? (DQ_W+1)'(33'h0_8000_0000) : (DQ_W+1)'(33'h0_7FFF_FFFF);
  assign q_sat = qr > lim;
  assign q_mag = q_sat ? lim[31:0] : qr[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      md  <= req.den[63] ? 64'(-req.den) : req.den;
      dq  <= {(req.num[63] ? 64'(-req.num) : req.num), {mi4_pkg::FRAC_BITS{1'b0}}};
      rem <= '0;
      neg <= req.num[63] ^ req.den[63];
    end else if (busy) begin
      if (cnt < ROUND_STEP) begin
        rem <= ge ? 64'(rem2 - {1'b0, md}) : rem2[63:0];
        dq  <= {dq[DQ_W-2:0], ge};
      end else if (cnt == ROUND_STEP) begin
        qr <= {1'b0, dq} + (DQ_W+1)'(up);
      end else begin
        quo <= neg ? -$signed(q_mag) : $signed(q_mag);
        sat <= q_sat;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.sat  = sat;

endmodule

[src/matrix_inverse_4x4_top.sv]
// Matrix inverter for order 3 or 4 (matrix_size), signed Q16.16 elements in
// row-major order, one per transfer. After the last element the block computes
// every cofactor and the determinant on one shared multiplier (per product: two
// store reads, issue, seven multiplier steps and a done strobe), then divides
// each transposed cofactor by the determinant on a bit-serial divider (per
// element: cofactor read, issue, 82 divider steps, done, output load). Result
// stalls hold the sequencer, and no elements are taken until the last result
// is loaded. A zero determinant gives a single singular result.
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_top
// Element store, sequencer, cofactor store and output register.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4_top (
  input logic    clk,
  input logic    rst,
  mi4_elem_if.sink   elem,
  mi4_cfg_if.sink    cfg,
  mi4_res_if.source  result
);

  typedef enum logic [10:0] {
    ST_LOAD  = 11'b00000000001,
    ST_ISSA  = 11'b00000000010,
    ST_ISSB  = 11'b00000000100,
    ST_ISSG  = 11'b00000001000,
    ST_WAIT  = 11'b00000010000,
    ST_CHECK = 11'b00000100000,
    ST_SING  = 11'b00001000000,
    ST_DIVA  = 11'b00010000000,
    ST_DIVG  = 11'b00100000000,
    ST_DIVW  = 11'b01000000000,
    ST_EMIT  = 11'b10000000000
  } state_t;

  typedef enum logic [1:0] {
    OP_M1  = 2'd0,
    OP_M2  = 2'd1,
    OP_M3  = 2'd2,
    OP_DET = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [63:0] val;
    logic               sat;
  } sadd_t;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  function automatic sadd_t sat_add(input logic signed [63:0] a,
                                    input logic signed [63:0] b);
    sadd_t r;
    logic signed [63:0] s;
    s     = a + b;
    r.val = s;
    r.sat = 1'b0;
    if (a[63] == b[63] && s[63] != a[63]) begin
      r.sat = 1'b1;
      r.val = a[63] ? -S64_MAX : S64_MAX;
    end else if (s == S64_MIN) begin
      r.sat = 1'b1;
      r.val = -S64_MAX;
    end
    return r;
  endfunction

  function automatic logic [3:0] sub_addr(input logic [1:0] sr, input logic [1:0] sc,
                                          input logic [1:0] er, input logic [1:0] ec,
                                          input logic n4);
    logic [1:0] row;
    logic [1:0] col;
    logic [3:0] a3;
    row = sr + {1'b0, sr >= er};
    col = sc + {1'b0, sc >= ec};
    a3  = {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
    return n4 ? {row, col} : a3;
  endfunction

  state_t state;
  op_t    op;
  logic [2:0] matrix_size;
  logic [4:0] load_count;
  logic [1:0] er;
  logic [1:0] ec;
  logic [1:0] j;
  logic       csat;
  logic       dsat;
  logic signed [63:0] p;
  logic signed [63:0] d2;
  logic signed [63:0] acc;
  logic signed [63:0] opa;
  logic signed [63:0] det;
  logic [15:0] cofsat;

  logic [31:0]        store [mi4_pkg::CELLS];
  logic signed [63:0] cof_mem [mi4_pkg::CELLS];
  logic [31:0]        store_rd;
  logic signed [63:0] cof_rd;

  logic               out_valid;
  logic signed [31:0] out_val;
  logic [1:0]         out_stat;
  logic               out_last;

  mi4_pkg::mul_req_t mreq;
  mi4_pkg::mul_rsp_t mrsp;
  mi4_pkg::div_req_t dreq;
  mi4_pkg::div_rsp_t drsp;

  logic       n4;
  logic [1:0] nm1;
  logic [4:0] nn;
  logic [1:0] ta;
  logic [1:0] tb;
  logic [3:0] addr_a;
  logic [3:0] addr_b;
  logic [3:0] st_addr;
  logic [3:0] cf_addr;
  logic       elem_xfer;
  logic       out_load;
  logic       cof_done;
  logic       neg_b;
  logic signed [63:0] add_a;
  logic signed [63:0] store_sx;
  logic signed [63:0] cof_wval;
  sadd_t      sum;

  assign n4  = matrix_size >= 3'd4;
  assign nm1 = n4 ? 2'd3 : 2'd2;
  assign nn  = n4 ? 5'd16 : 5'd9;
  assign ta  = (j == 2'd0) ? 2'd1 : 2'd0;
  assign tb  = (j == 2'd2) ? 2'd1 : 2'd2;

  always_comb begin
    unique case (op)
      OP_M1: begin
        addr_a = n4 ? sub_addr(2'd1, ta, er, ec, n4) : sub_addr(2'd0, 2'd0, er, ec, n4);
        addr_b = n4 ? sub_addr(2'd2, tb, er, ec, n4) : sub_addr(2'd1, 2'd1, er, ec, n4);
      end
      OP_M2: begin
        addr_a = n4 ? sub_addr(2'd1, tb, er, ec, n4) : sub_addr(2'd0, 2'd1, er, ec, n4);
        addr_b = n4 ? sub_addr(2'd2, ta, er, ec, n4) : sub_addr(2'd1, 2'd0, er, ec, n4);
      end
      OP_M3: begin
        addr_a = sub_addr(2'd0, j, er, ec, n4);
        addr_b = addr_a;
      end
      default: begin
        addr_a = {2'b00, ec};
        addr_b = addr_a;
      end
    endcase
  end

  assign st_addr = (state == ST_LOAD) ? load_count[3:0] :
                   (state == ST_ISSB) ? addr_b : addr_a;
  assign cf_addr = (state == ST_DIVA || state == ST_DIVG) ? {ec, er} : {2'b00, ec};

  assign elem_xfer = elem.valid && elem.ready;
  assign out_load  = (state == ST_SING || state == ST_EMIT) &&
                     (!out_valid || result.ready);
  assign store_sx  = {{32{store_rd[31]}}, store_rd};

  assign add_a = (op == OP_M2) ? p : (op == OP_M3) ? acc : det;
  assign neg_b = (op == OP_M2) || (op == OP_M3 && j == 2'd1);
  assign sum   = sat_add(add_a, neg_b ? -mrsp.res : mrsp.res);

  assign cof_done = (state == ST_WAIT) && mrsp.done &&
                    ((op == OP_M2 && !n4) || (op == OP_M3 && j == 2'd2));
  assign cof_wval = (er[0] ^ ec[0]) ? -sum.val : sum.val;

  always_comb begin
    mreq.start = (state == ST_ISSG);
    mreq.a     = opa;
    unique case (op)
      OP_M1, OP_M2: mreq.b = store_sx;
      OP_M3:        mreq.b = d2;
      default:      mreq.b = cof_rd;
    endcase
  end

  assign dreq.start = (state == ST_DIVG);
  assign dreq.num   = cof_rd;
  assign dreq.den   = det;

  mi4_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  mi4_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (elem_xfer) store[load_count[3:0]] <= elem.element_value;
    store_rd <= store[st_addr];
  end

  always_ff @(posedge clk) begin
    if (cof_done) cof_mem[{er, ec}] <= cof_wval;
    cof_rd <= cof_mem[cf_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      op          <= OP_M1;
      matrix_size <= 3'd4;
      load_count  <= '0;
      det         <= '0;
      out_valid   <= 1'b0;
      er          <= '0;
      ec          <= '0;
      j           <= '0;
      csat        <= 1'b0;
      dsat        <= 1'b0;
    end else begin
      if (out_valid && result.ready) out_valid <= 1'b0;
      if (cfg.valid) begin
        matrix_size <= cfg.matrix_size;
        load_count  <= '0;
      end

      unique case (state)
        ST_LOAD: begin
          if (elem_xfer) begin
            if (load_count + 5'd1 == nn) begin
              load_count <= '0;
              er    <= '0;
              ec    <= '0;
              j     <= '0;
              csat  <= 1'b0;
              op    <= OP_M1;
              state <= ST_ISSA;
            end else begin
              load_count <= load_count + 5'd1;
            end
          end
        end
        ST_ISSA: state <= ST_ISSB;
        ST_ISSB: begin
          opa   <= store_sx;
          state <= ST_ISSG;
        end
        ST_ISSG: state <= ST_WAIT;
        ST_WAIT: begin
          if (cof_done) begin
            cofsat[{er, ec}] <= csat | mrsp.sat | sum.sat;
            csat  <= 1'b0;
            j     <= '0;
            op    <= OP_M1;
            state <= ST_ISSA;
            if (ec == nm1) begin
              ec <= '0;
              if (er == nm1) begin
                er   <= '0;
                op   <= OP_DET;
                det  <= '0;
                dsat <= 1'b0;
              end else begin
                er <= er + 2'd1;
              end
            end else begin
              ec <= ec + 2'd1;
            end
          end else if (mrsp.done) begin
            unique case (op)
              OP_M1: begin
                p     <= mrsp.res;
                csat  <= csat | mrsp.sat;
                op    <= OP_M2;
                state <= ST_ISSA;
              end
              OP_M2: begin
                d2    <= sum.val;
                csat  <= csat | mrsp.sat | sum.sat;
                op    <= OP_M3;
                state <= ST_ISSA;
              end
              OP_M3: begin
                if (j == 2'd0) begin
                  acc  <= mrsp.res;
                  csat <= csat | mrsp.sat;
                end else begin
                  acc  <= sum.val;
                  csat <= csat | mrsp.sat | sum.sat;
                end
                j     <= j + 2'd1;
                op    <= OP_M1;
                state <= ST_ISSA;
              end
              default: begin
                det  <= sum.val;
                dsat <= dsat | mrsp.sat | sum.sat | cofsat[{2'b00, ec}];
                if (ec == nm1) begin
                  state <= ST_CHECK;
                end else begin
                  ec    <= ec + 2'd1;
                  state <= ST_ISSA;
                end
              end
            endcase
          end
        end
        ST_CHECK: begin
          er <= '0;
          ec <= '0;
          state <= (det == '0) ? ST_SING : ST_DIVA;
        end
        ST_SING: begin
          if (out_load) begin
            out_valid <= 1'b1;
            out_val   <= '0;
            out_stat  <= mi4_pkg::STAT_SING;
            out_last  <= 1'b1;
            state     <= ST_LOAD;
          end
        end
        ST_DIVA: state <= ST_DIVG;
        ST_DIVG: state <= ST_DIVW;
        ST_DIVW: if (drsp.done) state <= ST_EMIT;
        ST_EMIT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            out_val   <= drsp.quo;
            out_stat  <= (dsat | cofsat[{ec, er}] | drsp.sat) ?
                         mi4_pkg::STAT_SAT : mi4_pkg::STAT_OK;
            out_last  <= (er == nm1) && (ec == nm1);
            state     <= ST_DIVA;
            if (ec == nm1) begin
              ec <= '0;
              if (er == nm1) begin
                er    <= '0;
                state <= ST_LOAD;
              end else begin
                er <= er + 2'd1;
              end
            end else begin
              ec <= ec + 2'd1;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assign elem.ready             = (state == ST_LOAD);
  assign cfg.ready              = 1'b1;
  assign result.valid           = out_valid;
  assign result.inverse_element = out_val;
  assign result.status_code     = out_stat;
  assign result.last_result     = out_last;

`ifndef SYNTHESIS
  a_mul_no_early_done: assert property (@(posedge clk) disable iff (rst)
    mreq.start |=> !mrsp.done)
    else $error("multiplier done one cycle after start");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || result.ready))
    else $error("output register overwritten before transfer");

  a_load_in_range: assert property (@(posedge clk) disable iff (rst)
    elem_xfer |-> (load_count < nn))
    else $error("element transfer beyond matrix size");

  a_singular_form: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status_code == mi4_pkg::STAT_SING) |->
      (result.last_result && result.inverse_element == '0))
    else $error("singular result not zero or not last");
`endif

endmodule

[tb/tb_matrix_inverse_4x4_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_inverse_4x4_top
// Streams matrices of order 3 and 4 into the inverter under bursty element
// traffic and a stalling result sink, predicts every inverse element, its
// status and last mark in fixed point, and compares each result transfer.
// ----------------------------------------------------------------------------
module tb_matrix_inverse_4x4_top;

  localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;
  localparam int CFG_SETTLE = 3200;

  typedef enum int {CHK_PREDICT, CHK_IDENTITY, CHK_SINGULAR} row_check_t;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               last;
  } inv_result_t;

  typedef struct {
    logic [2:0]  size_val;
    logic [31:0] e[16];
    row_check_t  check;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  mi4_elem_if elem_ch();
  mi4_cfg_if  cfg_ch();
  mi4_res_if  res_ch();

  matrix_inverse_4x4_top dut (
    .clk    (clk),
    .rst    (rst),
    .elem   (elem_ch),
    .cfg    (cfg_ch),
    .result (res_ch)
  );

  always #6 clk = ~clk;

  longint      mstore[16];
  int unsigned load_cnt;
  logic [2:0]  size_reg;

  inv_result_t inv_expect_q[$];
  inv_result_t typed_q[$];
  bit          typed_mode;

  int error_cnt;
  int elem_cnt;
  int result_cnt;
  int matrix_cnt;
  int burst_left;
  int stall_cnt;

  function automatic logic [63:0] mag64(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint sum_sat(longint a, longint b, inout bit s);
    longint t;
    t = a + b;
    if ((a >= 0) == (b >= 0) && (t >= 0) != (a >= 0)) begin
      s = 1'b1;
      return a >= 0 ? SAT_MAX : -SAT_MAX;
    end
    if (t == -SAT_MAX - 1) begin
      s = 1'b1;
      return -SAT_MAX;
    end
    return t;
  endfunction

  function automatic longint prod_q(longint a, longint b, inout bit s);
    logic [127:0] x, y, p;
    bit neg;
    neg = (a < 0) != (b < 0);
    x = {64'b0, mag64(a)};
    y = {64'b0, mag64(b)};
    p = ((x * y) + (128'd1 << (mi4_pkg::FRAC_BITS - 1))) >> mi4_pkg::FRAC_BITS;
    if (p > 128'h7FFF_FFFF_FFFF_FFFF) begin
      s = 1'b1;
      p = 128'h7FFF_FFFF_FFFF_FFFF;
    end
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint det2_q(longint a, longint b, longint c, longint d,
                                    inout bit s);
    longint ad, bc;
    ad = prod_q(a, d, s);
    bc = prod_q(b, c, s);
    return sum_sat(ad, -bc, s);
  endfunction

  function automatic longint det3_q(longint m[16], inout bit s);
    longint t0, t1, t2;
    t0 = prod_q(m[0], det2_q(m[4], m[5], m[7], m[8], s), s);
    t1 = prod_q(m[1], det2_q(m[3], m[5], m[6], m[8], s), s);
    t2 = prod_q(m[2], det2_q(m[3], m[4], m[6], m[7], s), s);
    return sum_sat(sum_sat(t0, -t1, s), t2, s);
  endfunction

  function automatic longint cofactor_q(int n, int er, int ec, inout bit s);
    longint sub[16];
    longint d;
    int k;
    k = 0;
    foreach (sub[i]) sub[i] = 0;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (r != er && c != ec) begin
          sub[k] = mstore[r * n + c];
          k++;
        end
    d = (n == 4) ? det3_q(sub, s) : det2_q(sub[0], sub[1], sub[2], sub[3], s);
    return ((er + ec) % 2 == 1) ? -d : d;
  endfunction

  function automatic logic [31:0] quot_q(longint num, longint den, inout bit s);
    logic [127:0] nn, md, q, r, lim;
    bit neg;
    neg = (num < 0) != (den < 0);
    nn = {64'b0, mag64(num)} << mi4_pkg::FRAC_BITS;
    md = {64'b0, mag64(den)};
    q = nn / md;
    r = nn % md;
    if (r >= md - r) q = q + 1;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      s = 1'b1;
      q = lim;
    end
    if (neg) q = -q;
    return q[31:0];
  endfunction

  function automatic int eff_order();
    return size_reg < 3 ? 3 : (size_reg > 4 ? 4 : int'(size_reg));
  endfunction

  function automatic void predict_inverse(logic [31:0] raw);
    int n;
    longint det;
    longint cf;
    bit dsat, esat;
    inv_result_t res;
    n = eff_order();
    det = 0;
    dsat = 1'b0;
    if (load_cnt >= n * n) load_cnt = 0;
    mstore[load_cnt] = longint'(signed'(raw));
    load_cnt++;
    if (load_cnt < n * n) return;
    load_cnt = 0;
    matrix_cnt++;
    for (int i = 0; i < n; i++)
      det = sum_sat(det, prod_q(mstore[i], cofactor_q(n, 0, i, dsat), dsat), dsat);
    if (det == 0) begin
      res.value = '0;
      res.status = mi4_pkg::STAT_SING;
      res.last = 1'b1;
      inv_expect_q.push_back(res);
      return;
    end
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        esat = dsat;
        cf = cofactor_q(n, c, r, esat);
        res.value = quot_q(cf, det, esat);
        res.status = esat ? mi4_pkg::STAT_SAT : mi4_pkg::STAT_OK;
        res.last = (r * n + c == n * n - 1);
        inv_expect_q.push_back(res);
      end
  endfunction

  task automatic send_element(logic [31:0] v);
    int gap;
    int n_old;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        elem_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    elem_ch.valid <= 1'b1;
    elem_ch.element_value <= v;
    do @(posedge clk); while (!elem_ch.ready);
    burst_left--;
    elem_cnt++;
    n_old = inv_expect_q.size();
    predict_inverse(v);
    if (typed_mode && inv_expect_q.size() > n_old) begin
      while (inv_expect_q.size() > n_old) void'(inv_expect_q.pop_back());
      foreach (typed_q[i]) inv_expect_q.push_back(typed_q[i]);
    end
  endtask

  task automatic quiesce();
    elem_ch.valid <= 1'b0;
    burst_left = 0;
    wait (inv_expect_q.size() == 0);
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  task automatic write_size(logic [2:0] v);
    quiesce();
    cfg_ch.valid <= 1'b1;
    cfg_ch.matrix_size <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    size_reg = v;
    load_cnt = 0;
  endtask

  function automatic logic [31:0] rand_element(int mode);
    case (mode)
      0, 1, 2, 3, 4, 5: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
      6, 7:             return $urandom();
      default:          return 32'($urandom_range(0, 32'h400)) - 32'h200;
    endcase
  endfunction

  task automatic send_random_matrix();
    int n, mode;
    logic [31:0] m[16];
    n = eff_order();
    mode = $urandom_range(0, 9);
    foreach (m[i]) m[i] = rand_element(mode == 8 ? 0 : mode);
    if (mode == 8)
      for (int c = 0; c < n; c++) m[n + c] = m[c];
    for (int i = 0; i < n * n; i++) send_element(m[i]);
  endtask

  always @(posedge clk) begin
    inv_result_t exp_r;
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      res_ch.ready <= (stall_cnt[9:8] == 2'd0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (res_ch.valid && res_ch.ready) begin
        result_cnt++;
        if (inv_expect_q.size() == 0) begin
          error_cnt++;
          $display("%0t unexpected result: expected none actual %h/%0d/%0d", $realtime,
                   res_ch.inverse_element, res_ch.status_code, res_ch.last_result);
        end else begin
          exp_r = inv_expect_q.pop_front();
          if (res_ch.inverse_element !== exp_r.value || res_ch.status_code !== exp_r.status
              || res_ch.last_result !== exp_r.last) begin
            error_cnt++;
            $display("%0t mismatch: expected %h/%0d/%0d actual %h/%0d/%0d", $realtime,
                     exp_r.value, exp_r.status, exp_r.last, res_ch.inverse_element,
                     res_ch.status_code, res_ch.last_result);
          end
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    dir_row_t dir_rows[3];
    logic [2:0] size_plan[9];
    inv_result_t tr;
    int n;
    rst = 1'b1;
    elem_ch.valid = 1'b0;
    elem_ch.element_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.matrix_size = '0;
    foreach (mstore[i]) mstore[i] = 0;
    load_cnt = 0;
    size_reg = 3'd4;
    typed_mode = 1'b0;
    error_cnt = 0;
    elem_cnt = 0;
    result_cnt = 0;
    matrix_cnt = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir_rows[0].size_val = 3'd4;
    dir_rows[0].check = CHK_IDENTITY;
    for (int i = 0; i < 16; i++) dir_rows[0].e[i] = (i % 5 == 0) ? ONE_Q : '0;
    dir_rows[1].size_val = 3'd3;
    dir_rows[1].check = CHK_SINGULAR;
    for (int i = 0; i < 16; i++)
      dir_rows[1].e[i] = (i % 3 == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    dir_rows[2].size_val = 3'd3;
    dir_rows[2].check = CHK_PREDICT;
    dir_rows[2].e = '{0: 32'h7FFF_FFFF, 1: 32'h0000_0001, 2: 32'h8000_0000,
                      3: 32'hFFFF_0000, 4: 32'h0000_0100, 5: 32'h0001_0000,
                      6: 32'h8000_0000, 7: 32'h0000_0003, 8: 32'h7FFF_FFFF,
                      default: '0};

    foreach (dir_rows[k]) begin
      if (dir_rows[k].size_val != size_reg) write_size(dir_rows[k].size_val);
      n = eff_order();
      typed_q.delete();
      if (dir_rows[k].check == CHK_SINGULAR) begin
        tr.value = '0;
        tr.status = mi4_pkg::STAT_SING;
        tr.last = 1'b1;
        typed_q.push_back(tr);
      end else begin
        for (int i = 0; i < n * n; i++) begin
          tr.value = (i / n == i % n) ? ONE_Q : '0;
          tr.status = mi4_pkg::STAT_OK;
          tr.last = (i == n * n - 1);
          typed_q.push_back(tr);
        end
      end
      typed_mode = (dir_rows[k].check != CHK_PREDICT);
      for (int i = 0; i < n * n; i++) send_element(dir_rows[k].e[i]);
      typed_mode = 1'b0;
    end

    size_plan = '{3'd0, 3'd7, 3'd3, 3'd4, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4};
    foreach (size_plan[p]) begin
      write_size(size_plan[p]);
      n = eff_order();
      send_random_matrix();
      if ($urandom_range(0, 1) == 1) begin
        for (int i = $urandom_range(1, n * n - 1); i > 0; i--) begin
          send_element(rand_element($urandom_range(0, 9)));
        end
      end
    end
    while (elem_cnt < 200) begin
      send_random_matrix();
    end

    elem_ch.valid <= 1'b0;
    wait (inv_expect_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("run covered %0d elements, %0d matrices, %0d results checked", elem_cnt,
             matrix_cnt, result_cnt);
    $display("all eight size settings, restarts after partial loads, mismatches: %0d",
             error_cnt);
    if (error_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[files.f]
src/mi4_pkg.sv
src/mi4_elem_if.sv
src/mi4_cfg_if.sv
src/mi4_res_if.sv
src/mi4_mul.sv
src/mi4_div.sv
src/matrix_inverse_4x4_top.sv
tb/tb_matrix_inverse_4x4_top.sv
